### hdl/tci_pkg.sv
package tci_pkg;

   localparam int MaxPointsDefault = 1024;
   localparam int FracBitsDefault  = 16;
   localparam int NumComp          = 5;
   localparam int DataWidth        = 32;
   localparam int IndexWidth       = 10;

   localparam logic       ReqAppend = 1'b0;
   localparam logic       ReqQuery  = 1'b1;

   localparam logic [1:0] StatInterp = 2'd0;
   localparam logic [1:0] StatFirst  = 2'd1;
   localparam logic [1:0] StatLast   = 2'd2;
   localparam logic [1:0] StatEmpty  = 2'd3;

   typedef struct packed {
      logic                 req_type;
      logic signed [31:0]   time_value;
      logic signed [31:0]   comp_0;
      logic signed [31:0]   comp_1;
      logic signed [31:0]   comp_2;
      logic signed [31:0]   comp_3;
      logic signed [31:0]   comp_4;
   } req_type_type;

   typedef struct packed {
      logic signed [31:0]   out_0;
      logic signed [31:0]   out_1;
      logic signed [31:0]   out_2;
      logic signed [31:0]   out_3;
      logic signed [31:0]   out_4;
      logic [9:0]           lower_index;
      logic [1:0]           query_status;
   } rsp_type_type;

endpackage

### hdl/tci_if.sv
interface tci_req_if;
   logic                    valid;
   logic                    ready;
   tci_pkg::req_type_type   data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface tci_rsp_if;
   logic                    valid;
   logic                    ready;
   tci_pkg::rsp_type_type   data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### hdl/timed_curve_interpolator_unit.sv
// Channel | Dir | Handshake     | Item
// req     | in  | valid/ready   | append a point, or query at a time
// rsp     | out | valid/ready   | five components, lower index, status
//
// Append: one write to the stamp and point memories.
// Query: 2 clamp reads, a binary search by halving, bracket reads, a 32+FRAC_BITS
//   step restoring divider, then 5 serial multiplies.
// Reset clears the point count and the control state; memories are not cleared.
// A result waits in the output register; the next item is taken after it leaves.
module timed_curve_interpolator_unit #(
   parameter int MAX_POINTS = tci_pkg::MaxPointsDefault,
   parameter int FRAC_BITS  = tci_pkg::FracBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   tci_req_if.sink     req,
   tci_rsp_if.source   rsp
);
   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int DW = 32 + FRAC_BITS;          // dividend width
   localparam int QW = FRAC_BITS + 1;           // quotient bits kept
   localparam int SW = $clog2(DW + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RD0   = 4'd1;
   localparam logic [3:0] S_CK0   = 4'd2;
   localparam logic [3:0] S_CKL   = 4'd3;
   localparam logic [3:0] S_SRCH  = 4'd4;
   localparam logic [3:0] S_SCMP  = 4'd5;
   localparam logic [3:0] S_RDLO  = 4'd6;
   localparam logic [3:0] S_RDHI  = 4'd7;
   localparam logic [3:0] S_DIV   = 4'd8;
   localparam logic [3:0] S_CRD   = 4'd9;
   localparam logic [3:0] S_CMUL  = 4'd10;
   localparam logic [3:0] S_CADD  = 4'd11;
   localparam logic [3:0] S_EMIT  = 4'd12;
   localparam logic [3:0] S_OUT   = 4'd13;
   localparam logic [3:0] S_CLMP  = 4'd14;
   localparam logic [3:0] S_CLMW  = 4'd15;

   // memories: stamps, and points as five lanes of one row
   logic [31:0]  stamp_mem [MAX_POINTS];
   logic [159:0] point_mem [MAX_POINTS];
   logic [31:0]  stamp_rd_ff;
   logic [159:0] point_rd_ff;
   logic [AW-1:0] s_addr, p_addr;

   logic [3:0]   state_ff, state_in;
   logic [CW-1:0] count_ff;
   logic signed [31:0] t_ff;
   logic [AW-1:0] lo_ff, hi_ff, mid_ff, last_ff;
   logic signed [31:0] slo_ff;
   logic [31:0]  den_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] num_ff;
   logic [QW-1:0] quo_ff;
   logic [SW-1:0] step_ff;
   logic [2:0]   comp_ff;
   logic [159:0] plo_ff, phi_ff;
   logic signed [33:0] diff_ff;
   logic signed [QW+34:0] prod_ff;
   logic [159:0] res_ff;
   tci_pkg::rsp_type_type rsp_ff;
   logic         rsp_valid_ff;

   logic accept;
   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept    = req.valid && req.ready;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   logic [AW-1:0] count_idx;
   assign count_idx = count_ff[AW-1:0];

   always_comb begin
      s_addr = mid_ff;
      p_addr = mid_ff;
   end

   always_ff @(posedge clock) begin
      if (accept && req.data.req_type == tci_pkg::ReqAppend
          && count_ff < CW'(MAX_POINTS)) begin
         stamp_mem[count_idx] <= req.data.time_value;
         point_mem[count_idx] <= {req.data.comp_4, req.data.comp_3, req.data.comp_2,
                                  req.data.comp_1, req.data.comp_0};
      end
      stamp_rd_ff <= stamp_mem[s_addr];
      point_rd_ff <= point_mem[p_addr];
   end

   // fraction product, floor shift is an arithmetic shift
   logic signed [QW+34:0] mul_w;
   assign mul_w = $signed({1'b0, quo_ff}) * diff_ff;
   logic signed [QW+34:0] shr_w;
   assign shr_w = prod_ff >>> FRAC_BITS;

   logic [DW:0] trial;
   assign trial = {rem_ff, num_ff[DW-1]} - {{(DW-31){1'b0}}, den_ff};

   logic [31:0] lo_comp, hi_comp;
   assign lo_comp = plo_ff[comp_ff*32 +: 32];
   assign hi_comp = phi_ff[comp_ff*32 +: 32];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            // hold while a result waits
            if (accept && req.data.req_type == tci_pkg::ReqQuery)
               state_in = (count_ff == '0) ? S_EMIT : S_RD0;
         end
         S_RD0:  state_in = S_CK0;
         S_CK0:  state_in = (t_ff <= $signed(stamp_rd_ff)) ? S_CLMP : S_CKL;
         S_CKL:  state_in = S_SRCH;
         S_SRCH: begin
            if (t_ff >= $signed(stamp_rd_ff) && mid_ff == last_ff) state_in = S_CLMP;
            else if (hi_ff - lo_ff > AW'(1)) state_in = S_SCMP;
            else state_in = S_RDLO;
         end
         S_SCMP: state_in = S_SRCH;
         S_RDLO: state_in = S_RDHI;
         S_RDHI: state_in = S_DIV;
         S_DIV:  state_in = (step_ff == SW'(DW)) ? S_CRD : S_DIV;
         S_CRD:  state_in = S_CMUL;
         S_CMUL: state_in = S_CADD;
         S_CADD: state_in = (comp_ff == 3'd4) ? S_EMIT : S_CRD;
         S_EMIT: state_in = S_OUT;
         S_OUT:  state_in = S_IDLE;
         S_CLMP: state_in = S_CLMW;
         S_CLMW: state_in = S_EMIT;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_OUT) rsp_valid_ff <= 1'b1;
         else if (rsp.valid && rsp.ready) rsp_valid_ff <= 1'b0;
         if (accept && req.data.req_type == tci_pkg::ReqAppend
             && count_ff < CW'(MAX_POINTS))
            count_ff <= count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            // load only on a new item; a waiting result stays untouched
            if (accept) begin
               t_ff    <= req.data.time_value;
               last_ff <= AW'(count_ff - CW'(1));
               mid_ff  <= '0;
               res_ff  <= '0;
               rsp_ff.lower_index  <= '0;
               rsp_ff.query_status <= tci_pkg::StatEmpty;
            end
         end
         S_RD0: mid_ff <= last_ff;             // queue last stamp read
         S_CK0: begin
            // first-point test takes priority; re-read row 0 on clamp
            rsp_ff.lower_index  <= '0;
            rsp_ff.query_status <= tci_pkg::StatFirst;
            mid_ff <= (t_ff > $signed(stamp_rd_ff)) ? last_ff : '0;
         end
         S_CKL: begin
            lo_ff <= '0;
            hi_ff <= last_ff;
         end
         S_SRCH: begin
            if (t_ff >= $signed(stamp_rd_ff) && mid_ff == last_ff) begin
               rsp_ff.lower_index  <= 10'(last_ff);
               rsp_ff.query_status <= tci_pkg::StatLast;
            end else if (mid_ff == last_ff) begin
               // first probe of the search
               mid_ff <= AW'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
            end else if (hi_ff - lo_ff <= AW'(1)) begin
               mid_ff <= lo_ff;
            end else if ($signed(stamp_rd_ff) > t_ff) begin
               hi_ff  <= mid_ff;
               mid_ff <= AW'(({1'b0, lo_ff} + {1'b0, mid_ff}) >> 1);
            end else begin
               lo_ff  <= mid_ff;
               mid_ff <= AW'(({1'b0, mid_ff} + {1'b0, hi_ff}) >> 1);
            end
         end
         S_SCMP: begin
            if (hi_ff - lo_ff <= AW'(1)) mid_ff <= lo_ff;
         end
         S_RDLO: mid_ff <= hi_ff;
         S_RDHI: begin
            slo_ff  <= stamp_rd_ff;
            plo_ff  <= point_rd_ff;
            step_ff <= '0;
            comp_ff <= '0;
            rsp_ff.lower_index  <= 10'(lo_ff);
            rsp_ff.query_status <= tci_pkg::StatInterp;
         end
         S_DIV: begin
            if (step_ff == '0) begin
               phi_ff  <= point_rd_ff;
               den_ff  <= 32'($signed(stamp_rd_ff) - slo_ff);
               num_ff  <= {32'(t_ff - slo_ff), {FRAC_BITS{1'b0}}};
               rem_ff  <= '0;
               quo_ff  <= '0;
               step_ff <= SW'(1);
            end else begin
               step_ff <= step_ff + SW'(1);
               num_ff  <= num_ff << 1;
               if (!trial[DW]) begin
                  rem_ff <= trial[DW-1:0];
                  quo_ff <= {quo_ff[QW-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[DW-2:0], num_ff[DW-1]};
                  quo_ff <= {quo_ff[QW-2:0], 1'b0};
               end
            end
         end
         S_CRD: diff_ff <= $signed({hi_comp[31], hi_comp}) - $signed({lo_comp[31], lo_comp});
         S_CMUL: prod_ff <= mul_w;
         S_CADD: begin
            res_ff[comp_ff*32 +: 32] <= 32'($signed(lo_comp) + shr_w);
            comp_ff <= comp_ff + 3'd1;
         end
         S_EMIT: ;
         S_OUT: begin
            rsp_ff.out_0 <= res_ff[31:0];
            rsp_ff.out_1 <= res_ff[63:32];
            rsp_ff.out_2 <= res_ff[95:64];
            rsp_ff.out_3 <= res_ff[127:96];
            rsp_ff.out_4 <= res_ff[159:128];
         end
         S_CLMP: ;
         S_CLMW: res_ff <= point_rd_ff;
         default: ;
      endcase
   end

   // hold the input while a result waits
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req.ready) else $error("accept while result pending");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS)) else $error("point count overflow");
   a_out_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT) else $error("stray result");
endmodule
